>>> hdl/tmpf_pkg.sv
// tmpf_pkg: shared widths, codes and stage types for the threshold marking packet FIFO.
// No dependencies; every other file in hdl/ but tmpf_store uses it by scoped names.
`default_nettype none

package tmpf_pkg;

  // Fixed field widths
  localparam int OP_W   = 1;
  localparam int HDL_W  = 16;
  localparam int PLEN_W = 16;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 10;
  localparam int TOT_W  = 26;
  localparam int THR_W  = 11;
  localparam int CAP_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  // Scratch width for zero-extending lengths before truncation
  localparam int WIDE_W = 48;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OP_W-1:0] OP_PULL = 1'b1;

  // Result status codes
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_EN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP     = 2'd2;

  // Configuration register reset values
  localparam logic             MARK_EN_RST = 1'b0;
  localparam logic [THR_W-1:0] THRESH_RST  = 11'd40;
  localparam logic [CAP_W-1:0] CAP_RST     = 10'd1000;

  typedef struct packed {
    logic             mark_en;
    logic [THR_W-1:0] thresh;
    logic [CAP_W-1:0] cap;
  } cfg_t;

  // Decision for one beat, handed from the accept stage to the result stage
  typedef struct packed {
    logic             pull_ok;   // pull that found an entry: take data from the store
    logic             push_ok;   // push that was stored
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occ;       // occupancy after this beat
    logic [TOT_W-1:0] add_len;   // pushed length, mod 2^26
  } stage_t;

endpackage

`default_nettype wire

>>> hdl/tmpf_if.sv
// tmpf_in_if / tmpf_out_if: valid-ready channels for request and result beats.
// Depends on tmpf_pkg for field widths.
`default_nettype none

interface tmpf_in_if;
  logic                            valid;
  logic                            ready;
  logic [tmpf_pkg::OP_W-1:0]       operation;
  logic [tmpf_pkg::HDL_W-1:0]      packet_handle;
  logic [tmpf_pkg::PLEN_W-1:0]     packet_length;

  modport source (output valid, operation, packet_handle, packet_length, input ready);
  modport sink   (input valid, operation, packet_handle, packet_length, output ready);
endinterface

interface tmpf_out_if;
  logic                            valid;
  logic                            ready;
  logic [tmpf_pkg::ST_W-1:0]       status;
  logic [tmpf_pkg::HDL_W-1:0]      out_handle;
  logic [tmpf_pkg::PLEN_W-1:0]     out_length;
  logic                            out_mark;
  logic [tmpf_pkg::OCC_W-1:0]      occupancy;
  logic [tmpf_pkg::TOT_W-1:0]      total_bytes;

  modport source (output valid, status, out_handle, out_length, out_mark, occupancy,
                  total_bytes, input ready);
  modport sink   (input valid, status, out_handle, out_length, out_mark, occupancy,
                  total_bytes, output ready);
endinterface

`default_nettype wire

>>> hdl/tmpf_store.sv
// tmpf_store: packet entry ring storage, one write and one registered read port.
// Depends on nothing; entry layout is set by the caller.
`default_nettype none

module tmpf_store #(
  parameter int SLOTS = 1024,
  parameter int EW    = 33
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(SLOTS)-1:0] waddr_i,
  input  wire logic [EW-1:0]            wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(SLOTS)-1:0] raddr_i,
  output      logic [EW-1:0]            rdata_o
);

  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/tmpf_ctrl.sv
// tmpf_ctrl: accept stage; ring pointers, occupancy, full/empty/mark decision.
// Depends on tmpf_pkg; drives the store ports and the stage register toward tmpf_out.
`default_nettype none

module tmpf_ctrl #(
  parameter int SLOTS    = 1024,
  parameter int LEN_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tmpf_pkg::cfg_t                cfg_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [tmpf_pkg::OP_W-1:0]     in_op_i,
  input  wire logic [tmpf_pkg::HDL_W-1:0]    in_handle_i,
  input  wire logic [tmpf_pkg::PLEN_W-1:0]   in_length_i,
  input  wire logic                          s1_adv_i,
  output      logic                          s1_valid_o,
  output      tmpf_pkg::stage_t              s1_o,
  output      logic                          mem_we_o,
  output      logic [$clog2(SLOTS)-1:0]      mem_waddr_o,
  output      logic [tmpf_pkg::HDL_W+LEN_BITS:0] mem_wdata_o,
  output      logic                          mem_re_o,
  output      logic [$clog2(SLOTS)-1:0]      mem_raddr_o
);

  localparam int AW    = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int CMP_W = (CNT_W > tmpf_pkg::THR_W) ? CNT_W : tmpf_pkg::THR_W;

  logic [AW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             s1_valid_q, s1_valid_d;
  tmpf_pkg::stage_t s1_q, s1_d;

  logic                           in_acc, is_pull, full, empty, mark;
  logic                           push_ok, pull_ok;
  logic [tmpf_pkg::WIDE_W-1:0]    in_len_w, st_len_w;
  logic [LEN_BITS-1:0]            st_len;

  assign in_ready_o = !s1_valid_q || s1_adv_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_pull    = (in_op_i == tmpf_pkg::OP_PULL);

  // capacity above the ring size is capped at SLOTS
  assign full  = (CMP_W'(cnt_q) >= CMP_W'(cfg_i.cap)) || (cnt_q == CNT_W'(SLOTS));
  assign empty = (cnt_q == '0);
  // occupancy+1 > threshold  <=>  occupancy >= threshold
  assign mark  = cfg_i.mark_en && (CMP_W'(cnt_q) >= CMP_W'(cfg_i.thresh));

  assign push_ok = !is_pull && !full;
  assign pull_ok = is_pull && !empty;

  assign in_len_w = tmpf_pkg::WIDE_W'(in_length_i);
  assign st_len   = in_len_w[LEN_BITS-1:0];
  assign st_len_w = tmpf_pkg::WIDE_W'(st_len);

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    cnt_d      = cnt_q;
    s1_valid_d = s1_valid_q;
    s1_d       = s1_q;
    if (s1_adv_i) begin
      s1_valid_d = 1'b0;
    end
    if (in_acc) begin
      s1_valid_d = 1'b1;
      if (push_ok) begin
        tail_d = (tail_q == AW'(SLOTS - 1)) ? '0 : tail_q + 1'b1;
        cnt_d  = cnt_q + 1'b1;
      end
      if (pull_ok) begin
        head_d = (head_q == AW'(SLOTS - 1)) ? '0 : head_q + 1'b1;
        cnt_d  = cnt_q - 1'b1;
      end
      s1_d.pull_ok = pull_ok;
      s1_d.push_ok = push_ok;
      s1_d.status  = tmpf_pkg::ST_DONE;
      if (!is_pull && full) begin
        s1_d.status = tmpf_pkg::ST_FULL;
      end
      if (is_pull && empty) begin
        s1_d.status = tmpf_pkg::ST_EMPTY;
      end
      s1_d.occ     = tmpf_pkg::OCC_W'(cnt_d);
      s1_d.add_len = st_len_w[tmpf_pkg::TOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  assign s1_valid_o  = s1_valid_q;
  assign s1_o        = s1_q;
  assign mem_we_o    = in_acc && push_ok;
  assign mem_waddr_o = tail_q;
  assign mem_wdata_o = {mark, st_len, in_handle_i};
  assign mem_re_o    = in_acc && pull_ok;
  assign mem_raddr_o = head_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(SLOTS))
    else $error("occupancy above ring size");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (head_q == tail_q))
    else $error("empty ring with head and tail apart");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && push_ok) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("stored push did not bump occupancy");

  a_no_stall_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv_i) |-> !in_ready_o)
    else $error("accept stage overwritten while its beat waits");

endmodule

`default_nettype wire

>>> hdl/tmpf_out.sv
// tmpf_out: result stage; merges store read data, keeps the running byte total.
// Depends on tmpf_pkg; fed by tmpf_ctrl and tmpf_store.
`default_nettype none

module tmpf_out #(
  parameter int LEN_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s1_valid_i,
  input  wire tmpf_pkg::stage_t                  s1_i,
  input  wire logic [tmpf_pkg::HDL_W+LEN_BITS:0] rdata_i,
  output      logic                              s1_adv_o,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [tmpf_pkg::ST_W-1:0]         status_o,
  output      logic [tmpf_pkg::HDL_W-1:0]        handle_o,
  output      logic [tmpf_pkg::PLEN_W-1:0]       length_o,
  output      logic                              mark_o,
  output      logic [tmpf_pkg::OCC_W-1:0]        occ_o,
  output      logic [tmpf_pkg::TOT_W-1:0]        total_o
);

  logic                          valid_q;
  logic [tmpf_pkg::TOT_W-1:0]    total_q, total_d;
  logic [tmpf_pkg::ST_W-1:0]     status_q;
  logic [tmpf_pkg::HDL_W-1:0]    handle_q;
  logic [tmpf_pkg::PLEN_W-1:0]   length_q;
  logic                          mark_q;
  logic [tmpf_pkg::OCC_W-1:0]    occ_q;

  logic [tmpf_pkg::HDL_W-1:0]    rd_handle;
  logic [LEN_BITS-1:0]           rd_len;
  logic                          rd_mark;
  logic [tmpf_pkg::WIDE_W-1:0]   rd_len_w;

  assign {rd_mark, rd_len, rd_handle} = rdata_i;
  assign rd_len_w = tmpf_pkg::WIDE_W'(rd_len);

  assign s1_adv_o = s1_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    total_d = total_q;
    if (s1_i.push_ok) begin
      total_d = total_q + s1_i.add_len;
    end else if (s1_i.pull_ok) begin
      total_d = total_q - rd_len_w[tmpf_pkg::TOT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      total_q <= '0;
    end else begin
      if (s1_adv_o) begin
        valid_q <= 1'b1;
        total_q <= total_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv_o) begin
      status_q <= s1_i.status;
      occ_q    <= s1_i.occ;
      handle_q <= s1_i.pull_ok ? rd_handle : '0;
      length_q <= s1_i.pull_ok ? rd_len_w[tmpf_pkg::PLEN_W-1:0] : '0;
      mark_q   <= s1_i.pull_ok ? rd_mark : 1'b0;
    end
  end

  assign out_valid_o = valid_q;
  assign status_o    = status_q;
  assign handle_o    = handle_q;
  assign length_o    = length_q;
  assign mark_o      = mark_q;
  assign occ_o       = occ_q;
  assign total_o     = total_q;

  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv_o |=> $stable(total_q))
    else $error("byte total moved without a beat");

  a_drop_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv_o && !s1_i.push_ok && !s1_i.pull_ok) |=> $stable(total_q))
    else $error("dropped or empty beat changed byte total");

  a_ok_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_i && (s1_i.push_ok || s1_i.pull_ok)) |-> (s1_i.status == tmpf_pkg::ST_DONE))
    else $error("stored beat carries an error status");

endmodule

`default_nettype wire

>>> hdl/threshold_marking_packet_fifo.sv
// threshold_marking_packet_fifo: top level; config registers, accept stage, ring store,
// result stage. Depends on tmpf_pkg, tmpf_if, tmpf_store, tmpf_ctrl, tmpf_out.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+---------------------------------------------
//   req_i    | in  | valid/ready       | operation, packet_handle, packet_length
//   rsp_o    | out | valid/ready       | status, out_handle, out_length, out_mark,
//            |     |                   | occupancy, total_bytes
//   cfg      | in  | cfg_we_i, no wait | cfg_idx_i (0 mark enable, 1 threshold, 2 cap)
//
// One beat per cycle sustained while rsp_o.ready keeps the result stage moving. A request
// loads the accept register (and the store's read register) when it is accepted, then the
// result register, from which the result beat is offered on rsp_o.
// Pointers and occupancy update at acceptance; the byte total updates in the result stage.
// Reset clears pointers, counts and the byte total; the store itself is not cleared.
// A stalled result holds both stages; req_i.ready drops only when both are full.
`default_nettype none

module threshold_marking_packet_fifo #(
  parameter int SLOTS    = 1024,
  parameter int LEN_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  tmpf_in_if.sink                                req_i,
  tmpf_out_if.source                             rsp_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [tmpf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [tmpf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW = $clog2(SLOTS);
  localparam int EW = tmpf_pkg::HDL_W + LEN_BITS + 1;  // {mark, length, handle}

  tmpf_pkg::cfg_t   cfg_q, cfg_d;
  tmpf_pkg::stage_t s1;
  logic             s1_valid, s1_adv;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [EW-1:0]    mem_wdata, mem_rdata;

  // Config decode; indexes past the list are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tmpf_pkg::CFG_MARK_EN: cfg_d.mark_en = cfg_data_i[0];
        tmpf_pkg::CFG_THRESH:  cfg_d.thresh  = cfg_data_i[tmpf_pkg::THR_W-1:0];
        tmpf_pkg::CFG_CAP:     cfg_d.cap     = cfg_data_i[tmpf_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mark_en <= tmpf_pkg::MARK_EN_RST;
      cfg_q.thresh  <= tmpf_pkg::THRESH_RST;
      cfg_q.cap     <= tmpf_pkg::CAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Accept stage: decides push/pull outcome and moves the ring pointers
  tmpf_ctrl #(
    .SLOTS    (SLOTS),
    .LEN_BITS (LEN_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_op_i     (req_i.operation),
    .in_handle_i (req_i.packet_handle),
    .in_length_i (req_i.packet_length),
    .s1_adv_i    (s1_adv),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  // Ring storage; read data lines up with the accept-stage register
  tmpf_store #(
    .SLOTS (SLOTS),
    .EW    (EW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result stage: output register and running byte total
  tmpf_out #(
    .LEN_BITS (LEN_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid),
    .s1_i        (s1),
    .rdata_i     (mem_rdata),
    .s1_adv_o    (s1_adv),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_o    (rsp_o.status),
    .handle_o    (rsp_o.out_handle),
    .length_o    (rsp_o.out_length),
    .mark_o      (rsp_o.out_mark),
    .occ_o       (rsp_o.occupancy),
    .total_o     (rsp_o.total_bytes)
  );

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_idx_i == tmpf_pkg::CFG_CAP) |=>
      (cfg_q.cap == $past(cfg_data_i[tmpf_pkg::CAP_W-1:0])))
    else $error("capacity write not taken");

  a_rsp_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && !rsp_o.ready) |=> rsp_o.valid)
    else $error("result beat lost while stalled");

  a_adv_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |-> s1_valid)
    else $error("result stage took an empty accept stage");

endmodule

`default_nettype wire
